@@ hdl/confusion_matrix_accumulator_assert.svh @@
// assertion macros for the confusion matrix accumulator checker
// no dependencies; taken in by the checker file
`ifndef CONFUSION_MATRIX_ACCUMULATOR_ASSERT_SVH
`define CONFUSION_MATRIX_ACCUMULATOR_ASSERT_SVH

// condition and consequence in the same cycle
`define CMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define CMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cma_pkg.sv @@
// shared constants, types and helpers for the confusion matrix accumulator
// no dependencies
package cma_pkg;

  localparam int MAX_CLASSES = 64;
  localparam int MODE_COUNT  = 3;
  localparam int MODE_W      = 2;
  localparam int CLASS_W     = $clog2(MAX_CLASSES);
  localparam int ROW_W       = $clog2(MAX_CLASSES + 1);
  localparam int CFG_W       = 7;
  localparam int FLOAT_W     = 32;
  localparam int COUNT_W     = 32;
  localparam int TABLE_CELLS = MAX_CLASSES * MAX_CLASSES;
  localparam int CELL_DEPTH  = MODE_COUNT * TABLE_CELLS;
  localparam int ADDR_W      = MODE_W + 2 * CLASS_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] RES_SAMPLE = 2'd0;
  localparam logic [1:0] RES_CLEAR  = 2'd1;
  localparam logic [1:0] RES_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [MODE_W-1:0]  mode;
    logic               pred_seen;
    logic               label_seen;
    logic [CLASS_W-1:0] pred_row;
    logic [CLASS_W-1:0] label_row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic mode_ok(input logic [MODE_W-1:0] m);
    return m < MODE_W'(MODE_COUNT);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

@@ hdl/cma_queue.sv @@
// short command queue between the front and back parts
// depends on cma_pkg
module cma_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cma_pkg::cmd_t     din,
  input  logic              pop,
  output cma_pkg::cmd_t     dout,
  output cma_pkg::q_status_t status
);

  cma_pkg::cmd_t entries [cma_pkg::QUEUE_DEPTH];
  logic [cma_pkg::QPTR_W-1:0] wptr;
  logic [cma_pkg::QPTR_W-1:0] rptr;
  logic [cma_pkg::QCNT_W-1:0] fill;

  assign status.full  = (fill == cma_pkg::QCNT_W'(cma_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign dout = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + cma_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + cma_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + cma_pkg::QCNT_W'(1);
        2'b01:   fill <= fill - cma_pkg::QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hdl/cma_front.sv @@
// front part: takes input words, tracks the last nonzero rows of a sample
// and queues sample, clear and read commands; depends on cma_pkg
module cma_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cma_pkg::CFG_W-1:0]    classes_in_use,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [cma_pkg::MODE_W-1:0]   run_mode,
  input  logic [cma_pkg::FLOAT_W-1:0]  prediction_bits,
  input  logic [cma_pkg::FLOAT_W-1:0]  label_bits,
  input  logic                         last_row,
  input  logic [cma_pkg::CLASS_W-1:0]  read_prediction,
  input  logic [cma_pkg::CLASS_W-1:0]  read_label,
  input  cma_pkg::q_status_t           q_status,
  input  logic                         init_busy,
  output logic                         push,
  output cma_pkg::cmd_t                cmd
);

  logic [cma_pkg::CFG_W-1:0]   classes;
  logic [cma_pkg::ROW_W-1:0]   row_position;
  logic                        prediction_seen;
  logic [cma_pkg::CLASS_W-1:0] prediction_row;
  logic                        label_seen;
  logic [cma_pkg::CLASS_W-1:0] label_row;

  logic [cma_pkg::ROW_W-1:0]   active;
  logic                        in_range;
  logic                        pred_hit;
  logic                        label_hit;
  logic                        prediction_seen_next;
  logic [cma_pkg::CLASS_W-1:0] prediction_row_next;
  logic                        label_seen_next;
  logic [cma_pkg::CLASS_W-1:0] label_row_next;
  logic                        accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full | init_busy;
  assign accept    = in_valid & ~in_stall;

  always_comb begin
    if (classes == '0) begin
      active = cma_pkg::ROW_W'(1);
    end else if (cma_pkg::ROW_W'(classes) > cma_pkg::ROW_W'(cma_pkg::MAX_CLASSES)) begin
      active = cma_pkg::ROW_W'(cma_pkg::MAX_CLASSES);
    end else begin
      active = cma_pkg::ROW_W'(classes);
    end
  end

  // sign bit ignored so that -0 reads as zero
  assign in_range  = row_position < active;
  assign pred_hit  = in_range & (|prediction_bits[cma_pkg::FLOAT_W-2:0]);
  assign label_hit = in_range & (|label_bits[cma_pkg::FLOAT_W-2:0]);

  assign prediction_seen_next = prediction_seen | pred_hit;
  assign label_seen_next      = label_seen | label_hit;
  assign prediction_row_next  = pred_hit ? row_position[cma_pkg::CLASS_W-1:0] : prediction_row;
  assign label_row_next       = label_hit ? row_position[cma_pkg::CLASS_W-1:0] : label_row;

  always_comb begin
    push           = 1'b0;
    cmd.action     = action;
    cmd.mode       = run_mode;
    cmd.pred_seen  = prediction_seen_next;
    cmd.label_seen = label_seen_next;
    cmd.pred_row   = prediction_row_next;
    cmd.label_row  = label_row_next;
    case (action)
      cma_pkg::ACT_SAMPLE: begin
        push = accept & last_row;
      end
      cma_pkg::ACT_CLEAR: begin
        push = accept;
      end
      cma_pkg::ACT_READ: begin
        push           = accept;
        cmd.pred_seen  = 1'b0;
        cmd.label_seen = 1'b0;
        cmd.pred_row   = read_prediction;
        cmd.label_row  = read_label;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      classes         <= cma_pkg::CFG_W'(cma_pkg::MAX_CLASSES);
      row_position    <= '0;
      prediction_seen <= 1'b0;
      prediction_row  <= '0;
      label_seen      <= 1'b0;
      label_row       <= '0;
    end else begin
      if (cfg_valid) begin
        classes <= classes_in_use;
      end
      if (accept && action == cma_pkg::ACT_SAMPLE) begin
        if (last_row) begin
          row_position    <= '0;
          prediction_seen <= 1'b0;
          prediction_row  <= '0;
          label_seen      <= 1'b0;
          label_row       <= '0;
        end else begin
          if (row_position < cma_pkg::ROW_W'(cma_pkg::MAX_CLASSES)) begin
            row_position <= row_position + cma_pkg::ROW_W'(1);
          end
          prediction_seen <= prediction_seen_next;
          prediction_row  <= prediction_row_next;
          label_seen      <= label_seen_next;
          label_row       <= label_row_next;
        end
      end
    end
  end

endmodule

@@ hdl/cma_back.sv @@
// back part: count memory, mode totals, clearing sweeps and result register
// depends on cma_pkg
module cma_back (
  input  logic                         clk,
  input  logic                         rst,
  input  cma_pkg::q_status_t           q_status,
  input  cma_pkg::cmd_t                head,
  output logic                         pop,
  output logic                         init_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   result_kind,
  output logic                         counted,
  output logic [cma_pkg::CLASS_W-1:0]  found_prediction,
  output logic [cma_pkg::CLASS_W-1:0]  found_label,
  output logic [cma_pkg::COUNT_W-1:0]  cell_count,
  output logic [cma_pkg::COUNT_W-1:0]  mode_total
);

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_CLEAR  = 4'b1000
  } back_state_t;

  back_state_t                  state;
  cma_pkg::cmd_t                cur;
  logic [cma_pkg::ADDR_W-1:0]   sweep;
  logic [cma_pkg::COUNT_W-1:0]  totals [cma_pkg::MODE_COUNT];
  logic [cma_pkg::COUNT_W-1:0]  cells [cma_pkg::CELL_DEPTH];
  logic [cma_pkg::COUNT_W-1:0]  mem_q;

  logic                         mem_we;
  logic [cma_pkg::ADDR_W-1:0]   mem_waddr;
  logic [cma_pkg::COUNT_W-1:0]  mem_wdata;
  logic [cma_pkg::ADDR_W-1:0]   mem_raddr;
  logic [cma_pkg::ADDR_W-1:0]   cur_addr;
  logic                         cur_mode_ok;
  logic                         do_count;
  logic [cma_pkg::COUNT_W-1:0]  cell_new;
  logic [cma_pkg::COUNT_W-1:0]  total_cur;
  logic [cma_pkg::COUNT_W-1:0]  total_new;
  logic                         clear_done;
  logic                         init_done;

  assign init_busy   = (state == ST_INIT);
  assign pop         = (state == ST_IDLE) & ~q_status.empty & (~out_valid | ~out_stall);
  assign cur_mode_ok = cma_pkg::mode_ok(cur.mode);
  assign cur_addr    = {cur.mode, cur.pred_row, cur.label_row};
  assign mem_raddr   = cma_pkg::mode_ok(head.mode) ?
                       {head.mode, head.pred_row, head.label_row} : '0;

  assign do_count  = (cur.action == cma_pkg::ACT_SAMPLE) & cur_mode_ok &
                     cur.pred_seen & cur.label_seen;
  assign cell_new  = cma_pkg::sat_inc(mem_q);
  assign total_cur = cur_mode_ok ? totals[cur.mode] : '0;
  assign total_new = do_count ? cma_pkg::sat_inc(total_cur) : total_cur;

  assign init_done  = (sweep == cma_pkg::ADDR_W'(cma_pkg::CELL_DEPTH - 1));
  assign clear_done = ~cur_mode_ok |
                      (sweep == cma_pkg::ADDR_W'(cma_pkg::TABLE_CELLS - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = '0;
    case (state)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_CLEAR: begin
        mem_we    = cur_mode_ok;
        mem_waddr = {cur.mode, sweep[2*cma_pkg::CLASS_W-1:0]};
      end
      ST_ACCESS: begin
        mem_we    = do_count;
        mem_waddr = cur_addr;
        mem_wdata = cell_new;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // count memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    mem_q <= cells[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
      for (int m = 0; m < cma_pkg::MODE_COUNT; m++) begin
        totals[m] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (init_done) begin
            sweep <= '0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + cma_pkg::ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur   <= head;
            sweep <= '0;
            state <= (head.action == cma_pkg::ACT_CLEAR) ? ST_CLEAR : ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
          if (cur.action == cma_pkg::ACT_SAMPLE) begin
            result_kind      <= cma_pkg::RES_SAMPLE;
            counted          <= do_count;
            found_prediction <= cur.pred_row;
            found_label      <= cur.label_row;
            cell_count       <= do_count ? cell_new : '0;
            mode_total       <= total_new;
            if (do_count) begin
              totals[cur.mode] <= total_new;
            end
          end else begin
            result_kind      <= cma_pkg::RES_READ;
            counted          <= 1'b0;
            found_prediction <= '0;
            found_label      <= '0;
            cell_count       <= cur_mode_ok ? mem_q : '0;
            mode_total       <= total_cur;
          end
        end
        ST_CLEAR: begin
          sweep <= sweep + cma_pkg::ADDR_W'(1);
          if (clear_done) begin
            if (cur_mode_ok) begin
              totals[cur.mode] <= '0;
            end
            out_valid        <= 1'b1;
            result_kind      <= cma_pkg::RES_CLEAR;
            counted          <= 1'b0;
            found_prediction <= '0;
            found_label      <= '0;
            cell_count       <= '0;
            mode_total       <= '0;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

endmodule

@@ hdl/confusion_matrix_accumulator.sv @@
// top level of the confusion matrix accumulator
// depends on cma_pkg, cma_front, cma_queue and cma_back
//
// usage
// - cfg channel (cfg_valid/cfg_ready, classes_in_use): ready is always high,
//   write only while the block is idle; values of 0 act as 1, above 64 as 64
// - input channel (in_valid/in_stall): a sample is a run of row words, one a
//   cycle, the final one marked by last_row; clear and read are single words
// - output channel (out_valid/out_stall): one result word per finished
//   sample, clear or read; non-last rows and action 3 give no word
// - row words are taken one per cycle while in_stall is low; the front only
//   compares and the back sees one command per sample, not one per row word
// - a result word follows the last row or a read through the queue entry, the
//   queue pop with registered memory read and then the result register; a clear
//   zeroes its mode's table, one memory word a cycle through the write port
// - the back takes a new sample or read only once it is idle again, after the
//   read-modify-write on the count memory; a 4-word queue absorbs bursts
// - reset: a clearing pass over all 12288 count words follows, one a cycle,
//   with in_stall high; mode totals, row tracking and config reset at once
// - a stalled result holds in the output register; the back waits, the
//   queue fills and then in_stall rises
module confusion_matrix_accumulator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cma_pkg::CFG_W-1:0]    classes_in_use,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [cma_pkg::MODE_W-1:0]   run_mode,
  input  logic [cma_pkg::FLOAT_W-1:0]  prediction_bits,
  input  logic [cma_pkg::FLOAT_W-1:0]  label_bits,
  input  logic                         last_row,
  input  logic [cma_pkg::CLASS_W-1:0]  read_prediction,
  input  logic [cma_pkg::CLASS_W-1:0]  read_label,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   result_kind,
  output logic                         counted,
  output logic [cma_pkg::CLASS_W-1:0]  found_prediction,
  output logic [cma_pkg::CLASS_W-1:0]  found_label,
  output logic [cma_pkg::COUNT_W-1:0]  cell_count,
  output logic [cma_pkg::COUNT_W-1:0]  mode_total
);

  // commands between front and back
  cma_pkg::cmd_t      push_cmd;
  cma_pkg::cmd_t      head_cmd;
  cma_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic               init_busy;

  cma_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .classes_in_use  (classes_in_use),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .run_mode        (run_mode),
    .prediction_bits (prediction_bits),
    .label_bits      (label_bits),
    .last_row        (last_row),
    .read_prediction (read_prediction),
    .read_label      (read_label),
    .q_status        (q_status),
    .init_busy       (init_busy),
    .push            (push),
    .cmd             (push_cmd)
  );

  // short queue so the front keeps streaming while the back is busy
  cma_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (push_cmd),
    .pop    (pop),
    .dout   (head_cmd),
    .status (q_status)
  );

  // count memory, totals and the result register
  cma_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_status         (q_status),
    .head             (head_cmd),
    .pop              (pop),
    .init_busy        (init_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .counted          (counted),
    .found_prediction (found_prediction),
    .found_label      (found_label),
    .cell_count       (cell_count),
    .mode_total       (mode_total)
  );

endmodule

@@ hdl/cma_checker.sv @@
// port-level checks for the confusion matrix accumulator, bound to the top
// depends on cma_pkg and confusion_matrix_accumulator_assert.svh
`include "confusion_matrix_accumulator_assert.svh"

module cma_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   result_kind,
  input logic                         counted,
  input logic [cma_pkg::CLASS_W-1:0]  found_prediction,
  input logic [cma_pkg::CLASS_W-1:0]  found_label,
  input logic [cma_pkg::COUNT_W-1:0]  cell_count,
  input logic [cma_pkg::COUNT_W-1:0]  mode_total
);

  `CMA_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid && $stable(cell_count), "stalled result word dropped or changed")
  `CMA_ASSERT_NOW(a_plain_fields, out_valid && result_kind != cma_pkg::RES_SAMPLE, !counted && found_prediction == '0 && found_label == '0, "clear or read word carries sample fields")
  `CMA_ASSERT_NOW(a_count_seen, out_valid && result_kind == cma_pkg::RES_SAMPLE && counted, cell_count != '0 && mode_total != '0, "counted sample shows a zero count")
  `CMA_ASSERT_NOW(a_clear_zero, out_valid && result_kind == cma_pkg::RES_CLEAR, cell_count == '0 && mode_total == '0, "clear word with nonzero counts")

endmodule

bind confusion_matrix_accumulator cma_checker u_checker (.*);
